/* hw/rtl/cas_pkg.sv */
package cas_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int LIMIT_W    = 4;
	localparam int COORD_W    = 10;
	localparam int DIM_W      = 13;
	localparam int COUNT_W    = 4;

	localparam int MIN_DIM        = 3;
	localparam int DIM_RESET      = 64;
	localparam int BIRTH_RESET    = 4;
	localparam int DEATH_RESET    = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEATH_LIMIT = 2'd3;

	typedef struct packed {
		logic               out_is_wall;
		logic [COORD_W-1:0] cell_column;
		logic [COORD_W-1:0] cell_row;
		logic               frame_end;
	} result_t;

endpackage

/* hw/rtl/cas_cell_if.sv */
interface cas_cell_if;
	logic valid;
	logic ready;
	logic in_is_wall;
	logic frame_start;

	modport source (output valid, output in_is_wall, output frame_start, input ready);
	modport sink   (input valid, input in_is_wall, input frame_start, output ready);
endinterface

/* hw/rtl/cas_result_if.sv */
interface cas_result_if;
	logic                        valid;
	logic                        ready;
	logic                        out_is_wall;
	logic [cas_pkg::COORD_W-1:0] cell_column;
	logic [cas_pkg::COORD_W-1:0] cell_row;
	logic                        frame_end;

	modport source (
		output valid, output out_is_wall, output cell_column, output cell_row,
		output frame_end, input ready
	);
	modport sink (
		input valid, input out_is_wall, input cell_column, input cell_row,
		input frame_end, output ready
	);
endinterface

/* hw/rtl/cellular_automaton_smoothing.sv */
// One smoothing pass of a wall/floor grid streamed in raster order.
// feed: one cell per beat (in_is_wall, frame_start marks row 0 column 0).
// result: one smoothed cell per beat with its column, row and frame_end.
// cfg_we/cfg_index/cfg_wdata write grid_width, grid_height, birth_limit,
// death_limit; write only while no cell is in flight.
// While row r+1 arrives, cell (r+1,c) yields result (r,c-1); the last cell
// of a row also yields (r,width-1), so that cell takes two result beats.
// A cell is registered in stage s1, from which its results go into the queue.
// Throughput: one cell per cycle with no gap; the second result at a row end
// is drained while column 0 of the next row, which yields none, goes in.
// The two line buffers share one 2-bit-wide RAM of MAX_WIDTH entries with a
// registered read; they are not cleared, row 0 of each frame fills them.
// Reset empties the pipeline and the 4-entry result queue, restores the
// register defaults and sets the position to row 0 column 0.
// When the receiver stalls, results collect in the queue; feed.ready drops
// once fewer than two queue entries are free.
module cellular_automaton_smoothing #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	cas_cell_if.sink                        feed,
	cas_result_if.source                    result
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DW = cas_pkg::DIM_W;
	localparam int W_RESET = (cas_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : cas_pkg::DIM_RESET;
	localparam int H_RESET = (cas_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : cas_pkg::DIM_RESET;

	logic [DW-1:0]                    w_q, h_q;
	logic [cas_pkg::LIMIT_W-1:0]      birth_q, death_q;
	logic [DW-1:0]                    wdata_ext;
	logic [DW-1:0]                    w_clamp, h_clamp;

	logic [CW-1:0]                    col_q;
	logic [RW-1:0]                    row_q;
	logic [CW-1:0]                    col_eff;
	logic [RW-1:0]                    row_eff;
	logic [CW-1:0]                    col_next;
	logic [RW-1:0]                    row_next;
	logic                             pos_ok;

	logic [1:0]                       line_mem [MAX_WIDTH];

	logic                             valid_s1;
	logic                             lo_s1;
	logic [CW-1:0]                    col_s1;
	logic [RW-1:0]                    row_s1;
	logic [1:0]                       rd_s1;

	logic [5:0]                       window_q;
	logic                             accept;
	logic                             fire;
	logic                             up, mid, centre;
	logic [cas_pkg::COUNT_W-1:0]      cnt;
	logic                             emit_a, emit_b;
	logic [1:0]                       n_push;
	cas_pkg::result_t                 res_a, res_b;
	logic [CW-1:0]                    col_m1;
	logic [RW-1:0]                    row_m1;

	cas_pkg::result_t                 fifo_q [cas_pkg::FIFO_DEPTH];
	logic [cas_pkg::FIFO_AW-1:0]      head_q, tail_q;
	logic [cas_pkg::FIFO_CW-1:0]      count_q;
	logic                             pop;

	// configuration, dimensions kept clamped
	always_comb begin
		wdata_ext = DW'(cfg_wdata);
		if (wdata_ext < DW'(cas_pkg::MIN_DIM)) begin
			w_clamp = DW'(cas_pkg::MIN_DIM);
		end else if (wdata_ext > DW'(MAX_WIDTH)) begin
			w_clamp = DW'(MAX_WIDTH);
		end else begin
			w_clamp = wdata_ext;
		end
		if (wdata_ext < DW'(cas_pkg::MIN_DIM)) begin
			h_clamp = DW'(cas_pkg::MIN_DIM);
		end else if (wdata_ext > DW'(MAX_HEIGHT)) begin
			h_clamp = DW'(MAX_HEIGHT);
		end else begin
			h_clamp = wdata_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= DW'(W_RESET);
			h_q     <= DW'(H_RESET);
			birth_q <= cas_pkg::LIMIT_W'(cas_pkg::BIRTH_RESET);
			death_q <= cas_pkg::LIMIT_W'(cas_pkg::DEATH_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cas_pkg::REG_GRID_WIDTH:  w_q     <= w_clamp;
				cas_pkg::REG_GRID_HEIGHT: h_q     <= h_clamp;
				cas_pkg::REG_BIRTH_LIMIT: birth_q <= cfg_wdata[cas_pkg::LIMIT_W-1:0];
				cas_pkg::REG_DEATH_LIMIT: death_q <= cfg_wdata[cas_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign fire        = valid_s1 && (count_q <= cas_pkg::FIFO_CW'(cas_pkg::FIFO_DEPTH - 2));
	assign feed.ready  = !valid_s1 || fire;
	assign accept      = feed.valid && feed.ready;

	// raster position
	always_comb begin
		pos_ok  = !feed.frame_start && (DW'(col_q) < w_q) && (DW'(row_q) < h_q);
		col_eff = pos_ok ? col_q : '0;
		row_eff = pos_ok ? row_q : '0;
		if (DW'(col_eff) + DW'(1) >= w_q) begin
			col_next = '0;
			row_next = (DW'(row_eff) + DW'(1) >= h_q) ? '0 : row_eff + RW'(1);
		end else begin
			col_next = col_eff + CW'(1);
			row_next = row_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// line buffer ram: bit 0 upper line, bit 1 middle line
	always_ff @(posedge clk) begin
		if (fire) begin
			line_mem[col_s1] <= {lo_s1, rd_s1[1]};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_s1  <= feed.in_is_wall;
			col_s1 <= col_eff;
			row_s1 <= row_eff;
			if (fire && (col_s1 == col_eff)) begin
				rd_s1 <= {lo_s1, rd_s1[1]};
			end else begin
				rd_s1 <= line_mem[col_eff];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.ready) begin
			valid_s1 <= feed.valid;
		end
	end

	// 3x3 window and smoothing rule
	always_comb begin
		up     = rd_s1[0];
		mid    = rd_s1[1];
		centre = window_q[4];
		cnt    = cas_pkg::COUNT_W'(window_q[0]) + cas_pkg::COUNT_W'(window_q[1])
		       + cas_pkg::COUNT_W'(window_q[2]) + cas_pkg::COUNT_W'(window_q[3])
		       + cas_pkg::COUNT_W'(window_q[5]) + cas_pkg::COUNT_W'(up)
		       + cas_pkg::COUNT_W'(mid) + cas_pkg::COUNT_W'(lo_s1);
		col_m1 = col_s1 - CW'(1);
		row_m1 = row_s1 - RW'(1);
		emit_a = (row_s1 != '0) && (col_s1 != '0);
		emit_b = emit_a && (DW'(col_s1) == w_q - DW'(1));

		res_a.cell_column = cas_pkg::COORD_W'(col_m1);
		res_a.cell_row    = cas_pkg::COORD_W'(row_m1);
		res_a.frame_end   = 1'b0;
		if ((row_s1 == RW'(1)) || (col_s1 == CW'(1))) begin
			res_a.out_is_wall = 1'b1;
		end else if (centre) begin
			res_a.out_is_wall = !(cnt < death_q);
		end else begin
			res_a.out_is_wall = (cnt > birth_q);
		end

		res_b.out_is_wall = 1'b1;
		res_b.cell_column = cas_pkg::COORD_W'(col_s1);
		res_b.cell_row    = cas_pkg::COORD_W'(row_m1);
		res_b.frame_end   = (DW'(row_s1) == h_q - DW'(1));

		n_push = fire ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (fire) begin
			window_q <= {lo_s1, mid, up, window_q[5:3]};
		end
	end

	// result queue
	assign pop = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (fire && emit_a) begin
			fifo_q[tail_q] <= res_a;
		end
		if (fire && emit_b) begin
			fifo_q[tail_q + cas_pkg::FIFO_AW'(1)] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + cas_pkg::FIFO_AW'(n_push);
			if (pop) begin
				head_q <= head_q + cas_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + cas_pkg::FIFO_CW'(n_push) - cas_pkg::FIFO_CW'(pop);
		end
	end

	assign result.valid       = (count_q != '0);
	assign result.out_is_wall = fifo_q[head_q].out_is_wall;
	assign result.cell_column = fifo_q[head_q].cell_column;
	assign result.cell_row    = fifo_q[head_q].cell_row;
	assign result.frame_end   = fifo_q[head_q].frame_end;

endmodule

/* hw/rtl/cas_checker.sv */
module cas_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        out_is_wall,
	input logic [cas_pkg::COORD_W-1:0] cell_column,
	input logic [cas_pkg::COORD_W-1:0] cell_row,
	input logic                        frame_end
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_is_wall)
		&& $stable(cell_column) && $stable(cell_row) && $stable(frame_end))
		else $error("result beat changed while stalled");

	// top row is border
	a_top_wall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (cell_row == '0) |-> out_is_wall)
		else $error("row 0 result is not wall");

	// left column is border
	a_left_wall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (cell_column == '0) |-> out_is_wall)
		else $error("column 0 result is not wall");

	// frame end falls on a wall cell outside the left column
	a_end_wall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end |-> out_is_wall && (cell_column != '0))
		else $error("frame end on a non-border cell");

endmodule

bind cellular_automaton_smoothing cas_checker u_cas_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.out_is_wall (result.out_is_wall),
	.cell_column (result.cell_column),
	.cell_row    (result.cell_row),
	.frame_end   (result.frame_end)
);
